### rtl/afk_pkg.sv
// ----------------------------------------------------------------------------
// afk_pkg: shared constants, types and helpers
// Widths, Taylor series division constants and fixed-point helpers for the
// arm forward kinematics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int LENGTH_BITS = 12;
  localparam int OUT_BITS    = 19;
  localparam int CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOREARM     = 2'd2;

  localparam logic [LENGTH_BITS-1:0] BASE_HEIGHT_RST = LENGTH_BITS'(230);
  localparam logic [LENGTH_BITS-1:0] UPPER_ARM_RST   = LENGTH_BITS'(500);
  localparam logic [LENGTH_BITS-1:0] FOREARM_RST     = LENGTH_BITS'(500);

  // trig unit: Q30 results, 33-bit series terms, 35-bit signed sums
  localparam int TRIG_W  = 32;
  localparam int TERM_W  = 33;
  localparam int ACC_W   = 35;
  localparam int NTERMS  = 8;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  // latency: phase register, x stage, four stages per term, quadrant map
  localparam int SC_LAT   = 2 + 4 * NTERMS;
  localparam int CMB_LAT  = 4;
  localparam int PIPE_LAT = 1 + SC_LAT + CMB_LAT;

  // floor(2^33 / d) for the series divisors
  localparam logic [32:0] SIN_MAGIC [NTERMS] = '{
    33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
    33'd78090314,   33'd55063683,  33'd40904450,  33'd31580641};
  localparam logic [8:0] SIN_DIV [NTERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
  localparam logic [32:0] COS_MAGIC [NTERMS] = '{
    33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
    33'd95443717,   33'd65075262,  33'd47197442,  33'd35791394};
  localparam logic [8:0] COS_DIV [NTERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

  typedef struct packed {
    logic [1:0]              quad;
    logic [30:0]             x;
    logic [TERM_W-1:0]       ts;
    logic [TERM_W-1:0]       tc;
    logic [TERM_W-1:0]       qs;
    logic [TERM_W-1:0]       qc;
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] c;
  } sc_t;

  // (t * x) >> 30, truncated
  function automatic logic [TERM_W-1:0] mul_q30(input logic [TERM_W-1:0] t,
                                                input logic [30:0] x);
    logic [63:0] p;
    p = 64'(t) * 64'(x);
    return p[62:30];
  endfunction

  // estimate of n / d, low by at most one
  function automatic logic [TERM_W-1:0] div_est(input logic [TERM_W-1:0] n,
                                                input logic [32:0] m);
    logic [65:0] p;
    p = 66'(n) * 66'(m);
    return p[65:33];
  endfunction

  function automatic logic [TERM_W-1:0] div_fix(input logic [TERM_W-1:0] n,
                                                input logic [TERM_W-1:0] qe,
                                                input logic [8:0] d);
    logic [TERM_W-1:0] r;
    r = n - TERM_W'(qe * TERM_W'(d));
    return (r >= TERM_W'(d)) ? qe + TERM_W'(1) : qe;
  endfunction

  function automatic logic signed [TRIG_W-1:0] clamp_unit(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] one;
    one = ACC_W'(64'sd1073741824);
    if (v < 0) return '0;
    if (v > one) return TRIG_W'(one);
    return TRIG_W'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/afk_sincos.sv
// ----------------------------------------------------------------------------
// afk_sincos: pipelined Q30 sine and cosine
// Taylor series through the 17th/16th power, one term every four stages
// (two products, reciprocal estimate, correction and accumulate).
// ----------------------------------------------------------------------------
`default_nettype none

module afk_sincos (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [31:0]                       phase,
  output logic signed [afk_pkg::TRIG_W-1:0]      sin_out,
  output logic signed [afk_pkg::TRIG_W-1:0]      cos_out
);
  import afk_pkg::*;

  sc_t st_a [NTERMS];
  sc_t st_b [NTERMS];
  sc_t st_c [NTERMS];
  sc_t st_d [NTERMS+1];

  logic [60:0] xprod;
  logic [30:0] x0;
  logic signed [TRIG_W-1:0] s_cl, c_cl;

  assign xprod = 61'(phase[29:0]) * 61'(PI_HALF_Q30);
  assign x0    = 31'((xprod + 61'(1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      st_d[0].quad <= phase[31:30];
      st_d[0].x    <= x0;
      st_d[0].ts   <= TERM_W'(x0);
      st_d[0].tc   <= TERM_W'(1 << 30);
      st_d[0].qs   <= '0;
      st_d[0].qc   <= '0;
      st_d[0].s    <= ACC_W'(x0);
      st_d[0].c    <= ACC_W'(1 << 30);
    end
  end

  for (genvar k = 0; k < NTERMS; k++) begin : g_term
    always_ff @(posedge clk) begin
      sc_t na, nb, nc, nd;
      logic [TERM_W-1:0] ds, dc;
      if (en) begin
        na    = st_d[k];
        na.ts = mul_q30(st_d[k].ts, st_d[k].x);
        na.tc = mul_q30(st_d[k].tc, st_d[k].x);

        nb    = st_a[k];
        nb.ts = mul_q30(st_a[k].ts, st_a[k].x);
        nb.tc = mul_q30(st_a[k].tc, st_a[k].x);

        nc    = st_b[k];
        nc.qs = div_est(st_b[k].ts, SIN_MAGIC[k]);
        nc.qc = div_est(st_b[k].tc, COS_MAGIC[k]);

        ds    = div_fix(st_c[k].ts, st_c[k].qs, SIN_DIV[k]);
        dc    = div_fix(st_c[k].tc, st_c[k].qc, COS_DIV[k]);
        nd    = st_c[k];
        nd.ts = ds;
        nd.tc = dc;
        if (k % 2 == 0) begin
          nd.s = st_c[k].s - $signed({2'b0, ds});
          nd.c = st_c[k].c - $signed({2'b0, dc});
        end else begin
          nd.s = st_c[k].s + $signed({2'b0, ds});
          nd.c = st_c[k].c + $signed({2'b0, dc});
        end

        st_a[k]   <= na;
        st_b[k]   <= nb;
        st_c[k]   <= nc;
        st_d[k+1] <= nd;
      end
    end
  end

  assign s_cl = clamp_unit(st_d[NTERMS].s);
  assign c_cl = clamp_unit(st_d[NTERMS].c);

  always_ff @(posedge clk) begin
    if (en) begin
      case (st_d[NTERMS].quad)
        2'd0: begin
          sin_out <= s_cl;
          cos_out <= c_cl;
        end
        2'd1: begin
          sin_out <= c_cl;
          cos_out <= -s_cl;
        end
        2'd2: begin
          sin_out <= -s_cl;
          cos_out <= -c_cl;
        end
        default: begin
          sin_out <= -c_cl;
          cos_out <= s_cl;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/afk_combine.sv
// ----------------------------------------------------------------------------
// afk_combine: link products and tip coordinates
// Four stages: link products, reach and height rounding, projection onto
// the base yaw, final rounding with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_combine (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [afk_pkg::LENGTH_BITS-1:0]       l1,
  input  wire logic [afk_pkg::LENGTH_BITS-1:0]       l2,
  input  wire logic [afk_pkg::LENGTH_BITS-1:0]       l3,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     s1,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     c1,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     s2,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     c2,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     s23,
  input  wire logic signed [afk_pkg::TRIG_W-1:0]     c23,
  output logic signed [afk_pkg::OUT_BITS-1:0]        tip_x,
  output logic signed [afk_pkg::OUT_BITS-1:0]        tip_y,
  output logic signed [afk_pkg::OUT_BITS-1:0]        tip_z
);
  import afk_pkg::*;

  localparam int MW = LENGTH_BITS + 1 + TRIG_W;
  localparam int SW = MW + 2;
  localparam int RW = SW - 16;
  localparam int ZW = SW - 26;
  localparam int XW = RW + TRIG_W;
  localparam int HW = ((LENGTH_BITS + 5) > ZW ? (LENGTH_BITS + 5) : ZW) + 1;
  localparam int FW = XW - 40;

  logic signed [MW-1:0] m2, m3, n2, n3;
  logic signed [TRIG_W-1:0] s1_d1, c1_d1, s1_d2, c1_d2;
  logic signed [RW-1:0] reach;
  logic signed [ZW-1:0] zpart;
  logic signed [XW-1:0] xp, yp;
  logic signed [HW-1:0] zs;

  logic signed [SW-1:0] rsum, zsum;
  logic signed [XW-1:0] xr, yr;
  logic signed [FW-1:0] xf, yf;

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi, lo;
    hi = XW'(( 64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    lo = XW'(-(64'sd1 <<< (OUT_BITS - 1)));
    if (v > hi) return OUT_BITS'(hi);
    if (v < lo) return OUT_BITS'(lo);
    return OUT_BITS'(v);
  endfunction

  // ties away from zero: add half, minus one for negative values
  always_comb begin
    rsum = SW'(m2) + SW'(m3);
    rsum = rsum + SW'(1 << 15) - SW'(rsum[SW-1]);
    zsum = SW'(n2) + SW'(n3);
    zsum = zsum + SW'(1 << 25) - SW'(zsum[SW-1]);
    xr   = xp + XW'(64'sd1 <<< 39) - XW'(xp[XW-1]);
    yr   = yp + XW'(64'sd1 <<< 39) - XW'(yp[XW-1]);
    xf   = FW'(xr >>> 40);
    yf   = FW'(yr >>> 40);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2    <= $signed({1'b0, l2}) * c2;
      m3    <= $signed({1'b0, l3}) * c23;
      n2    <= $signed({1'b0, l2}) * s2;
      n3    <= $signed({1'b0, l3}) * s23;
      s1_d1 <= s1;
      c1_d1 <= c1;

      reach <= RW'(rsum >>> 16);
      zpart <= ZW'(zsum >>> 26);
      s1_d2 <= s1_d1;
      c1_d2 <= c1_d1;

      xp <= XW'(reach) * XW'(c1_d2);
      yp <= XW'(reach) * XW'(s1_d2);
      zs <= HW'($signed({1'b0, l1, 4'b0})) + HW'(zpart);

      tip_x <= sat(XW'(xf));
      tip_y <= sat(XW'(yf));
      tip_z <= sat(XW'(zs));
    end
  end

endmodule

`default_nettype wire

### rtl/arm_forward_kinematics_3dof.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_3dof: tool tip position of a yaw/pitch/pitch arm
// Joint angles in, x/y/z in 1/16 mm out, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one joint angle set per clock while out_ready stays high; the depth
// is set by the Taylor series trig pipeline, four stages per series term.
// The whole pipeline holds when a result is waiting and out_ready is low, so
// in_ready follows out_ready combinationally. Link lengths are to be written
// through the cfg port only while no item is in flight; the block itself
// does not enforce this.
`default_nettype none

module arm_forward_kinematics_3dof (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic [afk_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [afk_pkg::LENGTH_BITS-1:0]          cfg_data,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [afk_pkg::ANGLE_BITS-1:0]    base_angle,
  input  wire logic signed [afk_pkg::ANGLE_BITS-1:0]    shoulder_angle,
  input  wire logic signed [afk_pkg::ANGLE_BITS-1:0]    elbow_angle,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [afk_pkg::OUT_BITS-1:0]           tip_x,
  output logic signed [afk_pkg::OUT_BITS-1:0]           tip_y,
  output logic signed [afk_pkg::OUT_BITS-1:0]           tip_z
);
  import afk_pkg::*;

  logic [LENGTH_BITS-1:0] base_height, upper_arm_length, forearm_length;
  logic [PIPE_LAT-1:0] vld;
  logic en;
  logic [31:0] p1, p2, p23;
  logic signed [TRIG_W-1:0] s1, c1, s2, c2, s23, c23;

  assign en        = !vld[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height      <= BASE_HEIGHT_RST;
      upper_arm_length <= UPPER_ARM_RST;
      forearm_length   <= FOREARM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_HEIGHT: base_height      <= cfg_data;
        REG_UPPER_ARM:   upper_arm_length <= cfg_data;
        REG_FOREARM:     forearm_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // angles widened to a 32-bit phase; t2+t3 wraps mod one turn
  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= {base_angle, (32 - ANGLE_BITS)'(0)};
      p2  <= {shoulder_angle, (32 - ANGLE_BITS)'(0)};
      p23 <= {shoulder_angle + elbow_angle, (32 - ANGLE_BITS)'(0)};
    end
  end

  afk_sincos u_sc1 (.clk(clk), .en(en), .phase(p1),  .sin_out(s1),  .cos_out(c1));
  afk_sincos u_sc2 (.clk(clk), .en(en), .phase(p2),  .sin_out(s2),  .cos_out(c2));
  afk_sincos u_sc3 (.clk(clk), .en(en), .phase(p23), .sin_out(s23), .cos_out(c23));

  afk_combine u_cmb (
    .clk   (clk),
    .en    (en),
    .l1    (base_height),
    .l2    (upper_arm_length),
    .l3    (forearm_length),
    .s1    (s1),
    .c1    (c1),
    .s2    (s2),
    .c2    (c2),
    .s23   (s23),
    .c23   (c23),
    .tip_x (tip_x),
    .tip_y (tip_y),
    .tip_z (tip_z)
  );

endmodule

`default_nettype wire

### rtl/afk_checker.sv
// ----------------------------------------------------------------------------
// afk_port_checks: port level checks
// Output hold under stall, ready derivation and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_port_checks (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_ready,
  input  wire logic                                  out_valid,
  input  wire logic                                  out_ready,
  input  wire logic signed [afk_pkg::OUT_BITS-1:0]   tip_x,
  input  wire logic signed [afk_pkg::OUT_BITS-1:0]   tip_y,
  input  wire logic signed [afk_pkg::OUT_BITS-1:0]   tip_z
);
  import afk_pkg::*;

  // a pending result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tip_x) && $stable(tip_y)
      && $stable(tip_z))
    else $error("result changed while stalled");

  // input side only stalls when a result is stuck at the output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind arm_forward_kinematics_3dof afk_port_checks u_afk_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .tip_x     (tip_x),
  .tip_y     (tip_y),
  .tip_z     (tip_z)
);

`default_nettype wire
